// ===== rtl/tlik_pkg.sv =====
// Shared types, constants and the arctangent table for the leg inverse kinematics block.
// Has no dependencies; tlik_cordic and the top level refer to it by scoped names.
package tlik_pkg;

   // Widths and defaults.
   localparam int LINK_WIDTH             = 15;
   localparam int TURN_WIDTH             = 32;
   localparam int GUARD_SHIFT            = 16;
   localparam int HALF_OP_WIDTH          = 31;
   localparam int PROD_WIDTH             = 62;
   localparam int NORM_WIDTH             = 5;
   localparam int CSR_INDEX_WIDTH        = 2;
   localparam int COORD_WIDTH_DEFAULT    = 16;
   localparam int ANGLE_WIDTH_DEFAULT    = 16;
   localparam int CORDIC_STAGES_DEFAULT  = 16;

   // Register map.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_LINK = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_LINK  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_LINK  = 2'd2;

   localparam logic [LINK_WIDTH-1:0] OFFSET_LINK_RESET = 15'd2621;
   localparam logic [LINK_WIDTH-1:0] UPPER_LINK_RESET  = 15'd6554;
   localparam logic [LINK_WIDTH-1:0] LOWER_LINK_RESET  = 15'd6554;

   // Angles in fractions of a turn.
   localparam logic [TURN_WIDTH-1:0] QUARTER_TURN       = 32'h4000_0000;
   localparam logic [TURN_WIDTH-1:0] HALF_TURN          = 32'h8000_0000;
   localparam logic [TURN_WIDTH-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

   // How the target relates to the reach of the two lower links.
   typedef enum logic [1:0] {
      REACH_NORMAL,
      REACH_TOO_FAR,
      REACH_NEAR_LOWER,
      REACH_NEAR_UPPER
   } reach_type;

   // CORDIC arctangent of 2^-idx in units of 2^-32 turn.
   function automatic logic [TURN_WIDTH-1:0] atan_entry(input int unsigned idx);
      logic [TURN_WIDTH-1:0] val;
      case (idx)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051E;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2FA;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0029;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0003;
         29: val = 32'h0000_0001;
         30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/tlik_delay.sv =====
// Fixed-length register delay line that keeps side data in step with the arithmetic units.
// Depends on nothing.
module tlik_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            tap_ff[k] <= data_in;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

// ===== rtl/tlik_isqrt.sv =====
// Pipelined floor integer square root, one result bit per register stage.
// Depends on nothing.
module tlik_isqrt #(
   parameter int IN_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [IN_WIDTH-1:0]   operand,
   output logic [IN_WIDTH/2-1:0] root
);

   localparam int ROOT_WIDTH = IN_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;
   localparam int CAND_WIDTH = REM_WIDTH + 2;

   logic [IN_WIDTH-1:0]   rad_ff  [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      logic [IN_WIDTH-1:0]   prev_rad;
      logic [REM_WIDTH-1:0]  prev_rem;
      logic [ROOT_WIDTH-1:0] prev_root;
      logic [CAND_WIDTH-1:0] cand;
      logic [CAND_WIDTH-1:0] trial;
      logic [CAND_WIDTH-1:0] diff;

      if (k == 0) begin : g_head
         assign prev_rad  = operand;
         assign prev_rem  = '0;
         assign prev_root = '0;
      end else begin : g_body
         assign prev_rad  = rad_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
      end

      // Bring down the next two radicand bits and try the subtraction.
      assign cand  = {prev_rem, prev_rad[IN_WIDTH-1 -: 2]};
      assign trial = {2'b00, prev_root, 2'b01};
      assign diff  = cand - trial;

      always_ff @(posedge clock) begin
         rad_ff[k] <= prev_rad << 2;
         if (cand >= trial) begin
            rem_ff[k]  <= diff[REM_WIDTH-1:0];
            root_ff[k] <= {prev_root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= cand[REM_WIDTH-1:0];
            root_ff[k] <= {prev_root[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[ROOT_WIDTH-1];

endmodule

// ===== rtl/tlik_cordic.sv =====
// Pipelined CORDIC vectoring unit giving atan2(in_y, in_x) in 2^-32 turn.
// Uses tlik_pkg for the arctangent table.
module tlik_cordic #(
   parameter int IN_WIDTH = 16,
   parameter int STAGES   = 16
) (
   input  logic                                clock,
   input  logic signed [IN_WIDTH-1:0]          in_y,
   input  logic signed [IN_WIDTH-1:0]          in_x,
   output logic [tlik_pkg::TURN_WIDTH-1:0]     angle
);

   localparam int IW = IN_WIDTH + tlik_pkg::GUARD_SHIFT + 3;

   logic signed [IW-1:0]              x_ff    [STAGES+1];
   logic signed [IW-1:0]              y_ff    [STAGES+1];
   logic [tlik_pkg::TURN_WIDTH-1:0]   ang_ff  [STAGES+1];
   logic                              zero_ff [STAGES+1];

   logic signed [IW-1:0] xs;
   logic signed [IW-1:0] ys;

   assign xs = IW'(in_x) <<< tlik_pkg::GUARD_SHIFT;
   assign ys = IW'(in_y) <<< tlik_pkg::GUARD_SHIFT;

   // Fold the left half plane onto the right one.
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (xs[IW-1]) begin
         if (!ys[IW-1]) begin
            x_ff[0]   <= ys;
            y_ff[0]   <= -xs;
            ang_ff[0] <= tlik_pkg::QUARTER_TURN;
         end else begin
            x_ff[0]   <= -ys;
            y_ff[0]   <= xs;
            ang_ff[0] <= tlik_pkg::THREE_QUARTER_TURN;
         end
      end else begin
         x_ff[0]   <= xs;
         y_ff[0]   <= ys;
         ang_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [IW-1:0] dx;
      logic signed [IW-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][IW-1]) begin
            x_ff[i+1]   <= x_ff[i] + dx;
            y_ff[i+1]   <= y_ff[i] - dy;
            ang_ff[i+1] <= ang_ff[i] + tlik_pkg::atan_entry(i);
         end else begin
            x_ff[i+1]   <= x_ff[i] - dx;
            y_ff[i+1]   <= y_ff[i] + dy;
            ang_ff[i+1] <= ang_ff[i] - tlik_pkg::atan_entry(i);
         end
      end
   end

   assign angle = zero_ff[STAGES] ? '0 : ang_ff[STAGES];

endmodule

// ===== rtl/three_link_leg_inverse_kinematics.sv =====
// Top level of the three-link leg inverse kinematics pipeline.
// Depends on tlik_pkg, tlik_delay, tlik_isqrt and tlik_cordic.
//
//   Channel   Ports                              Handshake
//   request   req_leg_index, req_pos_x/y/z       start high while busy low
//   response  rsp_result_leg, rsp_*_angle,       rsp_strobe, one cycle, no backpressure
//             rsp_unreachable
//   config    csr_index, csr_data                csr_write_enable, no wait
//
// One transaction can enter per clock cycle outside reset. Each response passes
// through three chained square-root pipelines, one result bit per stage, and the
// CORDIC pipeline. Reset is synchronous, clears the valid bits and loads the link
// registers with their defaults; busy follows reset so nothing is taken during it.
// The receiver cannot stall, so the pipeline never holds.
module three_link_leg_inverse_kinematics #(
   parameter int COORD_WIDTH   = tlik_pkg::COORD_WIDTH_DEFAULT,
   parameter int ANGLE_WIDTH   = tlik_pkg::ANGLE_WIDTH_DEFAULT,
   parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_leg_index,
   input  logic signed [COORD_WIDTH-1:0]          req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]          req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]          req_pos_z,
   input  logic                                   csr_write_enable,
   input  logic [tlik_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tlik_pkg::LINK_WIDTH-1:0]        csr_data,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_result_leg,
   output logic signed [ANGLE_WIDTH-1:0]          rsp_abduction_angle,
   output logic signed [ANGLE_WIDTH-1:0]          rsp_hip_angle,
   output logic signed [ANGLE_WIDTH-1:0]          rsp_knee_angle,
   output logic                                   rsp_unreachable
);

   localparam int CW  = COORD_WIDTH;
   localparam int LW  = tlik_pkg::LINK_WIDTH;
   localparam int TW  = tlik_pkg::TURN_WIDTH;
   localparam int OW  = tlik_pkg::HALF_OP_WIDTH;
   localparam int PW  = tlik_pkg::PROD_WIDTH;
   localparam int KW  = tlik_pkg::NORM_WIDTH;
   // Signed width of r; also the width of the distance d.
   localparam int RW  = ((CW > LW) ? CW : LW) + 2;
   localparam int EW  = RW + 3;
   localparam int SW  = $clog2(EW);
   localparam int RSH = TW - ANGLE_WIDTH;
   localparam logic [TW-1:0] ROUND_HALF = (TW'(1) << RSH) >> 1;

   // Stage timing, counted in edges after the accepting edge.
   localparam int T_B  = 1;
   localparam int T_H  = T_B + CW;
   localparam int T_C  = T_H + 1;
   localparam int T_D  = T_C + 1;
   localparam int T_DD = T_D + RW;
   localparam int T_E1 = T_DD + 1;
   localparam int T_E5 = T_E1 + 4;
   localparam int T_R  = T_E5 + OW;
   localparam int T_K  = T_R + CORDIC_STAGES + 1;
   localparam int T_O  = T_K + 1;

   // Length of the fractional pair shift that brings the larger product to 2^60 or above.
   function automatic logic [KW-1:0] norm_pairs(input logic [PW-1:0] m);
      logic [5:0] len;
      logic [6:0] gap;
      len = '0;
      for (int i = 0; i < PW; i++) begin
         if (m[i]) begin
            len = 6'(i + 1);
         end
      end
      gap = 7'd62 - 7'(len);
      if ((len == '0) || (len >= 6'd61)) begin
         return '0;
      end
      return KW'(gap >> 1);
   endfunction

   // Round half up to the output width and let the result wrap.
   function automatic logic [ANGLE_WIDTH-1:0] round_angle(input logic [TW-1:0] a);
      logic [TW-1:0] sum;
      sum = a + ROUND_HALF;
      return sum[TW-1 -: ANGLE_WIDTH];
   endfunction

   // ---------------------------------------------------------------- link registers
   logic [LW-1:0] offset_link_ff;
   logic [LW-1:0] upper_link_ff;
   logic [LW-1:0] lower_link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_link_ff <= tlik_pkg::OFFSET_LINK_RESET;
         upper_link_ff  <= tlik_pkg::UPPER_LINK_RESET;
         lower_link_ff  <= tlik_pkg::LOWER_LINK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tlik_pkg::CSR_OFFSET_LINK: offset_link_ff <= csr_data;
            tlik_pkg::CSR_UPPER_LINK:  upper_link_ff  <= csr_data;
            tlik_pkg::CSR_LOWER_LINK:  lower_link_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- valid line
   // A transaction is taken whenever start is high outside reset; the valid
   // bit walks alongside the data and becomes the response strobe.
   logic             accept;
   logic [T_O:0]     valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[T_O-1:0], accept};
      end
   end

   // ---------------------------------------------------------------- stage A: capture
   logic [1:0]            a_leg_ff;
   logic signed [CW-1:0]  a_x_ff;
   logic signed [CW-1:0]  a_y_ff;
   logic signed [CW-1:0]  a_z_ff;

   always_ff @(posedge clock) begin
      a_leg_ff <= req_leg_index;
      a_x_ff   <= req_pos_x;
      a_y_ff   <= req_pos_y;
      a_z_ff   <= req_pos_z;
   end

   // The abduction cosine vanishes when z is zero but y is not.
   logic a_badcos;
   assign a_badcos = (a_z_ff == '0) && (a_y_ff != '0);

   // ---------------------------------------------------------------- stage B: y^2 + z^2
   logic [CW-1:0]    a_ay;
   logic [CW-1:0]    a_az;
   logic [2*CW-1:0]  ysq;
   logic [2*CW-1:0]  zsq;
   logic [2*CW-1:0]  hsq_ff;

   assign a_ay = a_y_ff[CW-1] ? CW'(-a_y_ff) : CW'(a_y_ff);
   assign a_az = a_z_ff[CW-1] ? CW'(-a_z_ff) : CW'(a_z_ff);
   assign ysq  = (2*CW)'(a_ay) * (2*CW)'(a_ay);
   assign zsq  = (2*CW)'(a_az) * (2*CW)'(a_az);

   always_ff @(posedge clock) begin
      hsq_ff <= ysq + zsq;
   end

   logic [CW-1:0] h_root;

   tlik_isqrt #(.IN_WIDTH(2 * CW)) u_sqrt_h (
      .clock   (clock),
      .operand (hsq_ff),
      .root    (h_root)
   );

   // ---------------------------------------------------------------- stage C: r = h - L1
   logic signed [RW-1:0] r_in;
   logic signed [RW-1:0] r_ff;
   logic signed [CW-1:0] c_x;

   assign r_in = $signed(RW'(h_root)) - $signed(RW'(offset_link_ff));

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   tlik_delay #(.WIDTH(CW), .DEPTH(T_C)) u_dly_x (
      .clock    (clock),
      .data_in  (a_x_ff),
      .data_out (c_x)
   );

   // ---------------------------------------------------------------- stage D: x^2 + r^2
   logic [CW-1:0]    c_ax;
   logic [RW-2:0]    c_ar;
   logic [2*RW-1:0]  xsq;
   logic [2*RW-1:0]  rsq;
   logic [2*RW-1:0]  dsq_ff;

   assign c_ax = c_x[CW-1] ? CW'(-c_x) : CW'(c_x);
   assign c_ar = r_ff[RW-1] ? (RW-1)'(-r_ff) : (RW-1)'(r_ff);
   assign xsq  = (2*RW)'(c_ax) * (2*RW)'(c_ax);
   assign rsq  = (2*RW)'(c_ar) * (2*RW)'(c_ar);

   always_ff @(posedge clock) begin
      dsq_ff <= xsq + rsq;
   end

   logic [RW-1:0] d_root;

   tlik_isqrt #(.IN_WIDTH(2 * RW)) u_sqrt_d (
      .clock   (clock),
      .operand (dsq_ff),
      .root    (d_root)
   );

   // ---------------------------------------------------------------- stage E1: triangle sides
   logic signed [EW-1:0]  d_s;
   logic signed [EW-1:0]  l2_s;
   logic signed [EW-1:0]  l3_s;
   logic signed [EW-1:0]  e_in;
   logic signed [EW-1:0]  f_in;
   logic signed [EW-1:0]  g_in;
   logic signed [EW-1:0]  u_in;
   tlik_pkg::reach_type   reach_in;
   logic signed [EW-1:0]  e_ff;
   logic signed [EW-1:0]  f_ff;
   logic signed [EW-1:0]  g_ff;
   logic signed [EW-1:0]  u_ff;
   tlik_pkg::reach_type   reach_ff;
   logic                  baddist_ff;

   assign d_s  = $signed(EW'(d_root));
   assign l2_s = $signed(EW'(upper_link_ff));
   assign l3_s = $signed(EW'(lower_link_ff));
   assign e_in = d_s + l2_s - l3_s;
   assign f_in = d_s + l3_s - l2_s;
   assign g_in = l2_s + l3_s - d_s;
   assign u_in = l2_s + l3_s + d_s;

   // The target is out of reach when the triangle cannot close; which side fails
   // decides whether the elbow folds fully or stretches out.
   always_comb begin
      if (g_in[EW-1]) begin
         reach_in = tlik_pkg::REACH_TOO_FAR;
      end else if (f_in[EW-1]) begin
         reach_in = tlik_pkg::REACH_NEAR_LOWER;
      end else if (e_in[EW-1]) begin
         reach_in = tlik_pkg::REACH_NEAR_UPPER;
      end else begin
         reach_in = tlik_pkg::REACH_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      f_ff       <= f_in;
      g_ff       <= g_in;
      u_ff       <= u_in;
      reach_ff   <= reach_in;
      baddist_ff <= (d_root == '0) || (upper_link_ff == '0) || (lower_link_ff == '0);
   end

   // ---------------------------------------------------------------- stage E2: scale below 2^31
   logic [SW-1:0]  s_in;
   logic [OW-1:0]  es_ff;
   logic [OW-1:0]  fs_ff;
   logic [OW-1:0]  gs_ff;
   logic [OW-1:0]  us_ff;

   // All four sides shift together until the sum side fits in 31 bits.
   always_comb begin
      s_in = '0;
      for (int i = OW; i < EW; i++) begin
         if (u_ff[i]) begin
            s_in = SW'(i - (OW - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      es_ff <= OW'($unsigned(e_ff) >> s_in);
      fs_ff <= OW'($unsigned(f_ff) >> s_in);
      gs_ff <= OW'($unsigned(g_ff) >> s_in);
      us_ff <= OW'($unsigned(u_ff) >> s_in);
   end

   // ---------------------------------------------------------------- stage E3: products
   // Knee-side angle A uses f*g over u*e; angle B uses e*g over u*f.
   logic [PW-1:0] pa_ff;
   logic [PW-1:0] qa_ff;
   logic [PW-1:0] pb_ff;
   logic [PW-1:0] qb_ff;

   always_ff @(posedge clock) begin
      pa_ff <= PW'(fs_ff) * PW'(gs_ff);
      qa_ff <= PW'(us_ff) * PW'(es_ff);
      pb_ff <= PW'(es_ff) * PW'(gs_ff);
      qb_ff <= PW'(us_ff) * PW'(fs_ff);
   end

   // ---------------------------------------------------------------- stage E4: shift count
   logic [PW-1:0]  pa4_ff;
   logic [PW-1:0]  qa4_ff;
   logic [PW-1:0]  pb4_ff;
   logic [PW-1:0]  qb4_ff;
   logic [KW-1:0]  ka_ff;
   logic [KW-1:0]  kb_ff;

   always_ff @(posedge clock) begin
      pa4_ff <= pa_ff;
      qa4_ff <= qa_ff;
      pb4_ff <= pb_ff;
      qb4_ff <= qb_ff;
      ka_ff  <= norm_pairs(pa_ff | qa_ff);
      kb_ff  <= norm_pairs(pb_ff | qb_ff);
   end

   // ---------------------------------------------------------------- stage E5: normalize
   logic [PW-1:0] pa5_ff;
   logic [PW-1:0] qa5_ff;
   logic [PW-1:0] pb5_ff;
   logic [PW-1:0] qb5_ff;

   always_ff @(posedge clock) begin
      pa5_ff <= pa4_ff << {ka_ff, 1'b0};
      qa5_ff <= qa4_ff << {ka_ff, 1'b0};
      pb5_ff <= pb4_ff << {kb_ff, 1'b0};
      qb5_ff <= qb4_ff << {kb_ff, 1'b0};
   end

   logic [OW-1:0] pa_root;
   logic [OW-1:0] qa_root;
   logic [OW-1:0] pb_root;
   logic [OW-1:0] qb_root;

   tlik_isqrt #(.IN_WIDTH(PW)) u_sqrt_pa (
      .clock (clock), .operand (pa5_ff), .root (pa_root)
   );
   tlik_isqrt #(.IN_WIDTH(PW)) u_sqrt_qa (
      .clock (clock), .operand (qa5_ff), .root (qa_root)
   );
   tlik_isqrt #(.IN_WIDTH(PW)) u_sqrt_pb (
      .clock (clock), .operand (pb5_ff), .root (pb_root)
   );
   tlik_isqrt #(.IN_WIDTH(PW)) u_sqrt_qb (
      .clock (clock), .operand (qb5_ff), .root (qb_root)
   );

   // ---------------------------------------------------------------- CORDIC units
   // The abduction and hip arctangents are fed late so that all four CORDIC
   // units finish in the same cycle.
   logic signed [CW-1:0]      r_y;
   logic signed [CW-1:0]      r_z;
   logic signed [CW-1:0]      r_x;
   logic signed [RW-1:0]      r_r;
   logic [TW-1:0]             abd_ang;
   logic [TW-1:0]             hip_ang;
   logic [TW-1:0]             ha_ang;
   logic [TW-1:0]             hb_ang;

   tlik_delay #(.WIDTH(2 * CW), .DEPTH(T_R)) u_dly_yz (
      .clock    (clock),
      .data_in  ({a_y_ff, a_z_ff}),
      .data_out ({r_y, r_z})
   );

   tlik_delay #(.WIDTH(CW + RW), .DEPTH(T_R - T_C)) u_dly_xr (
      .clock    (clock),
      .data_in  ({c_x, r_ff}),
      .data_out ({r_x, r_r})
   );

   tlik_cordic #(.IN_WIDTH(CW), .STAGES(CORDIC_STAGES)) u_cordic_abd (
      .clock (clock), .in_y (r_y), .in_x (r_z), .angle (abd_ang)
   );

   tlik_cordic #(.IN_WIDTH(RW), .STAGES(CORDIC_STAGES)) u_cordic_hip (
      .clock (clock), .in_y (RW'(r_x)), .in_x (r_r), .angle (hip_ang)
   );

   tlik_cordic #(.IN_WIDTH(OW + 1), .STAGES(CORDIC_STAGES)) u_cordic_ha (
      .clock (clock),
      .in_y  ($signed({1'b0, pa_root})),
      .in_x  ($signed({1'b0, qa_root})),
      .angle (ha_ang)
   );

   tlik_cordic #(.IN_WIDTH(OW + 1), .STAGES(CORDIC_STAGES)) u_cordic_hb (
      .clock (clock),
      .in_y  ($signed({1'b0, pb_root})),
      .in_x  ($signed({1'b0, qb_root})),
      .angle (hb_ang)
   );

   // ---------------------------------------------------------------- side data to the end
   logic [1:0]           k_leg;
   logic                 k_badcos;
   logic [1:0]           k_reach_bits;
   logic                 k_baddist;
   tlik_pkg::reach_type  k_reach;

   tlik_delay #(.WIDTH(3), .DEPTH(T_K)) u_dly_leg (
      .clock    (clock),
      .data_in  ({a_leg_ff, a_badcos}),
      .data_out ({k_leg, k_badcos})
   );

   tlik_delay #(.WIDTH(3), .DEPTH(T_K - T_E1)) u_dly_reach (
      .clock    (clock),
      .data_in  ({reach_ff, baddist_ff}),
      .data_out ({k_reach_bits, k_baddist})
   );

   assign k_reach = tlik_pkg::reach_type'(k_reach_bits);

   // ---------------------------------------------------------------- final angles
   logic [TW-1:0] a_ang;
   logic [TW-1:0] b_ang;
   logic [TW-1:0] hip_sum;
   logic [TW-1:0] knee_sum;

   // The half-angle arctangents are doubled; failed triangles pin the elbow.
   always_comb begin
      case (k_reach)
         tlik_pkg::REACH_NORMAL: begin
            a_ang = ha_ang << 1;
            b_ang = hb_ang << 1;
         end
         tlik_pkg::REACH_NEAR_LOWER: begin
            a_ang = '0;
            b_ang = tlik_pkg::HALF_TURN;
         end
         tlik_pkg::REACH_NEAR_UPPER: begin
            a_ang = tlik_pkg::HALF_TURN;
            b_ang = '0;
         end
         default: begin
            a_ang = '0;
            b_ang = '0;
         end
      endcase
   end

   assign hip_sum  = hip_ang - a_ang;
   assign knee_sum = a_ang + b_ang;

   logic [1:0]              o_leg_ff;
   logic [ANGLE_WIDTH-1:0]  o_abd_ff;
   logic [ANGLE_WIDTH-1:0]  o_hip_ff;
   logic [ANGLE_WIDTH-1:0]  o_knee_ff;
   logic                    o_unr_ff;

   always_ff @(posedge clock) begin
      o_leg_ff  <= k_leg;
      o_abd_ff  <= round_angle(abd_ang);
      o_hip_ff  <= round_angle(hip_sum);
      o_knee_ff <= round_angle(knee_sum);
      o_unr_ff  <= k_badcos || k_baddist || (k_reach != tlik_pkg::REACH_NORMAL);
   end

   assign rsp_strobe          = valid_ff[T_O];
   assign rsp_result_leg      = o_leg_ff;
   assign rsp_abduction_angle = $signed(o_abd_ff);
   assign rsp_hip_angle       = $signed(o_hip_ff);
   assign rsp_knee_angle      = $signed(o_knee_ff);
   assign rsp_unreachable     = o_unr_ff;

endmodule

// ===== bench/three_link_leg_inverse_kinematics_tb.sv =====
// Testbench for the three-link leg inverse kinematics pipeline: random and directed foot
// targets under several link settings, each response checked against an in-bench predictor.
// Depends on tlik_pkg and the three_link_leg_inverse_kinematics RTL.
`timescale 1ns / 100ps

module three_link_leg_inverse_kinematics_tb;

   localparam int CW = tlik_pkg::COORD_WIDTH_DEFAULT;
   localparam int AW = tlik_pkg::ANGLE_WIDTH_DEFAULT;
   localparam int STAGES = tlik_pkg::CORDIC_STAGES_DEFAULT;
   // The drain wait covers the pipeline depth with margin.
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 400000;
   // Register index past the end of the map; writes to it are ignored.
   localparam logic [tlik_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      logic [1:0] leg;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } target_type;

   typedef struct {
      logic [1:0] leg;
      logic [AW-1:0] abd;
      logic [AW-1:0] hip;
      logic [AW-1:0] knee;
      logic unreach;
   } joints_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_leg_index = '0;
   logic signed [CW-1:0] req_pos_x = '0;
   logic signed [CW-1:0] req_pos_y = '0;
   logic signed [CW-1:0] req_pos_z = '0;
   logic csr_write_enable = 1'b0;
   logic [tlik_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [tlik_pkg::LINK_WIDTH-1:0] csr_data = '0;
   logic rsp_strobe;
   logic [1:0] rsp_result_leg;
   logic signed [AW-1:0] rsp_abduction_angle;
   logic signed [AW-1:0] rsp_hip_angle;
   logic signed [AW-1:0] rsp_knee_angle;
   logic rsp_unreachable;

   // Bench copy of the link registers, kept in step with every write.
   longint offset_len = tlik_pkg::OFFSET_LINK_RESET;
   longint upper_len = tlik_pkg::UPPER_LINK_RESET;
   longint lower_len = tlik_pkg::LOWER_LINK_RESET;

   target_type pending_targets[$];
   joints_type expected_joints[$];
   target_type cur_target;
   int gap_left = 0;
   int failures = 0;
   int cycle_count = 0;

   three_link_leg_inverse_kinematics dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_leg_index(req_leg_index), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_strobe(rsp_strobe), .rsp_result_leg(rsp_result_leg),
      .rsp_abduction_angle(rsp_abduction_angle), .rsp_hip_angle(rsp_hip_angle),
      .rsp_knee_angle(rsp_knee_angle), .rsp_unreachable(rsp_unreachable)
   );

   always #2 clock = ~clock;

   // Floor square root, one result bit per step, as the hardware does it.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Vectoring CORDIC: angle of (xx, yy) in 2^-32 turn.
   function automatic logic [31:0] vector_angle(input longint yy, input longint xx);
      longint vx, vy, t, dx, dy;
      logic [31:0] ang = '0;
      if (yy == 0 && xx == 0) return '0;
      vx = xx <<< 16;
      vy = yy <<< 16;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy; vy = -t; ang = tlik_pkg::QUARTER_TURN;
         end else begin
            vx = -vy; vy = t; ang = tlik_pkg::THREE_QUARTER_TURN;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx += dx; vy -= dy; ang += tlik_pkg::atan_entry(i);
         end else begin
            vx -= dx; vy += dy; ang -= tlik_pkg::atan_entry(i);
         end
      end
      return ang;
   endfunction

   // Twice the angle of (sqrt(c*w), sqrt(a*b)); this is the arccosine in half-angle form.
   function automatic logic [31:0] law_of_cosines_angle(input longint unsigned a,
         input longint unsigned b, input longint unsigned c, input longint unsigned w);
      longint unsigned p, q;
      logic [31:0] ang;
      p = a * b;
      q = c * w;
      while ((p | q) != 0 && (p | q) < (64'd1 << 60)) begin
         p <<= 2;
         q <<= 2;
      end
      ang = vector_angle(longint'(floor_sqrt(p)), longint'(floor_sqrt(q)));
      return ang << 1;
   endfunction

   function automatic logic [AW-1:0] round_angle(input logic [31:0] a);
      logic [31:0] s;
      s = a + (32'd1 << (31 - AW));
      return s[31 -: AW];
   endfunction

   function automatic joints_type solve_leg(input target_type tg);
      joints_type res;
      longint x, y, z, r, e, f, g, u;
      longint unsigned h, d, ax, ay, az, ar;
      logic [31:0] abd, a_ang, b_ang;
      int s = 0;
      logic bad;
      x = tg.x; y = tg.y; z = tg.z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      abd = vector_angle(y, z);
      h = floor_sqrt(ay * ay + az * az);
      r = longint'(h) - offset_len;
      ar = (r < 0) ? -r : r;
      d = floor_sqrt(ax * ax + ar * ar);
      e = longint'(d) + upper_len - lower_len;
      f = longint'(d) + lower_len - upper_len;
      g = upper_len + lower_len - longint'(d);
      u = upper_len + lower_len + longint'(d);
      bad = (z == 0 && y != 0) || d == 0 || upper_len == 0 || lower_len == 0;
      if (g < 0) begin
         a_ang = '0; b_ang = '0; bad = 1'b1;
      end else if (f < 0) begin
         a_ang = '0; b_ang = tlik_pkg::HALF_TURN; bad = 1'b1;
      end else if (e < 0) begin
         a_ang = tlik_pkg::HALF_TURN; b_ang = '0; bad = 1'b1;
      end else begin
         while ((u >>> s) >= (64'sd1 <<< 31)) s++;
         a_ang = law_of_cosines_angle(f >>> s, g >>> s, u >>> s, e >>> s);
         b_ang = law_of_cosines_angle(e >>> s, g >>> s, u >>> s, f >>> s);
      end
      res.leg = tg.leg;
      res.abd = round_angle(abd);
      res.hip = round_angle(vector_angle(x, r) - a_ang);
      res.knee = round_angle(a_ang + b_ang);
      res.unreach = bad;
      return res;
   endfunction

   // Driver: hold a transaction until it is taken, then maybe idle a while.
   always @(posedge clock) begin
      target_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_joints.insert(expected_joints.size(), solve_leg(cur_target));
            void'(pending_targets.pop_front());
            case ($urandom_range(0, 19))
               0: gap_left = $urandom_range(10, 40);
               1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
               default: gap_left = 0;
            endcase
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_targets.size() > 0) begin
            nxt = pending_targets[0];
            cur_target = nxt;
            req_leg_index <= nxt.leg;
            req_pos_x <= nxt.x;
            req_pos_y <= nxt.y;
            req_pos_z <= nxt.z;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed response must match the oldest outstanding prediction.
   always @(posedge clock) begin
      joints_type exp_j;
      if (!reset && rsp_strobe) begin
         if (expected_joints.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            exp_j = expected_joints.pop_front();
            if (rsp_result_leg !== exp_j.leg) begin
               $error("result_leg expected %0d got %0d", exp_j.leg, rsp_result_leg);
               failures++;
            end
            if (rsp_abduction_angle !== exp_j.abd) begin
               $error("abduction_angle expected %0d got %0d",
                      $signed(exp_j.abd), rsp_abduction_angle);
               failures++;
            end
            if (rsp_hip_angle !== exp_j.hip) begin
               $error("hip_angle expected %0d got %0d", $signed(exp_j.hip), rsp_hip_angle);
               failures++;
            end
            if (rsp_knee_angle !== exp_j.knee) begin
               $error("knee_angle expected %0d got %0d", $signed(exp_j.knee), rsp_knee_angle);
               failures++;
            end
            if (rsp_unreachable !== exp_j.unreach) begin
               $error("unreachable expected %0d got %0d", exp_j.unreach, rsp_unreachable);
               failures++;
            end
         end
      end
   end

   // Watchdog against a hung pipeline.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("three_link_leg_inverse_kinematics: mismatch");
         $finish;
      end
   end

   task automatic add_target(input int leg, input int x, input int y, input int z);
      target_type tg;
      tg.leg = leg[1:0];
      tg.x = x[CW-1:0];
      tg.y = y[CW-1:0];
      tg.z = z[CW-1:0];
      pending_targets.insert(pending_targets.size(), tg);
   endtask

   // Coordinate mostly within the leg's reach, so the law-of-cosines path is exercised.
   function automatic int reach_coord();
      int reach;
      reach = int'(offset_len + upper_len + lower_len);
      if (reach > 32767) reach = 32767;
      return $urandom_range(0, 2 * reach) - reach;
   endfunction

   task automatic add_random_targets(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            add_target($urandom_range(0, 3), $urandom, $urandom, $urandom);
         else
            add_target($urandom_range(0, 3), reach_coord(), reach_coord(),
                       reach_coord());
      end
   endtask

   // Wait until every transaction has been answered, so the block is idle.
   task automatic drain();
      while (pending_targets.size() > 0 || expected_joints.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_link(input logic [tlik_pkg::CSR_INDEX_WIDTH-1:0] idx,
                             input int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value[tlik_pkg::LINK_WIDTH-1:0];
      case (idx)
         tlik_pkg::CSR_OFFSET_LINK: offset_len = value & 32'h7FFF;
         tlik_pkg::CSR_UPPER_LINK: upper_len = value & 32'h7FFF;
         tlik_pkg::CSR_LOWER_LINK: lower_len = value & 32'h7FFF;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_links(input int l1, input int l2, input int l3);
      write_link(tlik_pkg::CSR_OFFSET_LINK, l1);
      write_link(tlik_pkg::CSR_UPPER_LINK, l2);
      write_link(tlik_pkg::CSR_LOWER_LINK, l3);
   endtask

   // Targets close to the hip, where one link is longer than the other plus the distance.
   task automatic add_near_targets();
      add_target(0, 0, 0, int'(offset_len) + 50);
      add_target(1, 30, 0, -int'(offset_len) - 20);
      add_target(2, -40, 10, int'(offset_len));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions at the reset link lengths.
      add_target(0, 0, 0, 0);
      add_target(1, 0, 100, 0);                 // abduction cosine is zero
      add_target(2, 0, -100, 0);
      add_target(0, 0, 0, 2621);                // foot exactly at the hip: zero distance
      add_target(1, 32767, 32767, 32767);       // far out of reach
      add_target(2, -32768, -32768, -32768);
      add_target(3, 1000, 0, 10000);            // leg number beyond the leg count
      add_target(0, -5000, 3000, 9000);
      add_target(1, 5000, -3000, -9000);
      add_target(2, 0, 0, 15729);               // fully stretched leg
      add_target(0, 0, 0, -32768);
      add_target(1, 32767, 0, 1);
      add_target(2, -1, -1, -1);
      add_target(3, 100, 32767, -32768);
      add_random_targets(60);
      drain();

      // Long links: nothing is too far.
      set_links(1, 32767, 32767);
      add_target(0, 32767, 32767, 32767);
      add_target(1, -32768, 0, 0);
      add_random_targets(60);
      drain();

      // Short links: almost everything is out of reach.
      set_links(32767, 1, 1);
      add_target(2, 0, 0, 32767);
      add_random_targets(40);
      drain();

      // Long lower link: targets near the hip fold the knee to a half turn.
      set_links(500, 1000, 20000);
      add_near_targets();
      add_random_targets(40);
      drain();

      // Long upper link: the opposite folding case.
      set_links(500, 20000, 1000);
      add_near_targets();
      add_random_targets(40);
      drain();

      // Zero link lengths, and a write to an unused index that must be ignored.
      set_links(0, 0, 6554);
      write_link(CSR_UNUSED_INDEX, 12345);
      add_near_targets();
      add_random_targets(30);
      drain();
      set_links(2621, 6554, 0);
      add_random_targets(30);
      drain();

      // Random link settings.
      for (int k = 0; k < 3; k++) begin
         set_links($urandom_range(1, 32767), $urandom_range(1, 20000),
                   $urandom_range(1, 20000));
         add_random_targets(50);
         drain();
      end

      if (failures == 0) begin
         $display("three_link_leg_inverse_kinematics: match");
      end else begin
         $display("three_link_leg_inverse_kinematics: mismatch");
      end
      $finish;
   end

endmodule
